### hdl/atacc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the affine transform accumulator.
// Used by every module of the block; depends on nothing else.
package atacc_pkg;

  localparam int unsigned MaxSteps   = 48;
  localparam int unsigned CordicIters = 24;

  localparam logic signed [31:0] OneQ16     = 32'sd65536;
  localparam logic signed [31:0] Sat32Max   = 32'sh7fffffff;
  localparam logic signed [31:0] Sat32Min   = 32'sh80000000;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic [31:0]        PiQ30      = 32'd3373259426;

  localparam logic [2:0] CMD_AFFINE    = 3'd0;
  localparam logic [2:0] CMD_TRANSLATE = 3'd1;
  localparam logic [2:0] CMD_SCALE     = 3'd2;
  localparam logic [2:0] CMD_ROTATE    = 3'd3;
  localparam logic [2:0] CMD_SKEW      = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COR,
    ST_TAN,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic        start;
    logic [14:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic               done;
    logic signed [33:0] cos_v;
    logic signed [33:0] sin_v;
  } cordic_rsp_t;

  function automatic logic signed [33:0] atan_f(input logic [4:0] i);
    logic signed [33:0] r;
    unique case (i)
      5'd0:  r = 34'sd843314856;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043836;
      5'd3:  r = 34'sd133525158;
      5'd4:  r = 34'sd67021686;
      5'd5:  r = 34'sd33543515;
      5'd6:  r = 34'sd16775850;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194282;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048575;
      5'd11: r = 34'sd524287;
      5'd12: r = 34'sd262143;
      5'd13: r = 34'sd131071;
      5'd14: r = 34'sd65535;
      5'd15: r = 34'sd32767;
      5'd16: r = 34'sd16383;
      5'd17: r = 34'sd8191;
      5'd18: r = 34'sd4095;
      5'd19: r = 34'sd2047;
      5'd20: r = 34'sd1023;
      5'd21: r = 34'sd511;
      5'd22: r = 34'sd255;
      5'd23: r = 34'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32_f(input logic signed [50:0] v);
    logic signed [31:0] r;
    if (v > 51'(Sat32Max)) begin
      r = Sat32Max;
    end else if (v < 51'(Sat32Min)) begin
      r = Sat32Min;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### hdl/atacc_cordic.sv
`timescale 1ns / 1ps
// Iterative rotation-mode CORDIC giving Q30 cosine and sine, one iteration per cycle.
// Depends on atacc_pkg.
module atacc_cordic (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  atacc_pkg::cordic_req_t   req_i,
  output atacc_pkg::cordic_rsp_t   rsp_o
);
  import atacc_pkg::*;

  logic signed [33:0] x_q, y_q, z_q;
  logic signed [33:0] x_d, y_d, z_d;
  logic [4:0]         iter_q;
  logic               busy_q, done_q;
  logic [46:0]        zmul;

  assign zmul = 47'(req_i.angle) * 47'(PiQ30);

  always_comb begin
    if (!z_q[33]) begin
      x_d = x_q - (y_q >>> iter_q);
      y_d = y_q + (x_q >>> iter_q);
      z_d = z_q - atan_f(iter_q);
    end else begin
      x_d = x_q + (y_q >>> iter_q);
      y_d = y_q - (x_q >>> iter_q);
      z_d = z_q + atan_f(iter_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        iter_q <= iter_q + 5'd1;
        if (iter_q == 5'(CordicIters - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q <= CordicGain;
      y_q <= '0;
      z_q <= {3'b000, zmul[46:16]};
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.cos_v = x_q;
  assign rsp_o.sin_v = y_q;

endmodule

### hdl/atacc_tan.sv
`timescale 1ns / 1ps
// Tangent from Q30 cosine and sine by a restoring divider, one quotient bit per cycle.
// Depends on atacc_pkg.
module atacc_tan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                neg_i,
  input  logic signed [33:0]  cos_i,
  input  logic signed [33:0]  sin_i,
  output logic                done_o,
  output logic signed [31:0]  tan_o
);
  import atacc_pkg::*;

  logic signed [33:0] num, den;
  logic [33:0]        num_mag;
  logic [32:0]        den_q, rem_q, rem_d;
  logic [48:0]        dq_q, dq_d;
  logic [33:0]        r2;
  logic               ge;
  logic [5:0]         cnt_q;
  logic               busy_q, done_q, sgn_q;
  logic signed [31:0] tan_q, fin;

  assign num     = neg_i ? cos_i : sin_i;
  assign den     = neg_i ? sin_i : cos_i;
  assign num_mag = num[33] ? 34'(-num) : 34'(num);

  always_comb begin
    r2    = {rem_q, dq_q[48]};
    ge    = r2 >= {1'b0, den_q};
    rem_d = ge ? 33'(r2 - {1'b0, den_q}) : r2[32:0];
    dq_d  = {dq_q[47:0], ge};
    if (sgn_q) begin
      fin = (dq_d > 49'h0_8000_0000) ? Sat32Min : 32'(-dq_d);
    end else begin
      fin = (dq_d > 49'h0_7fff_ffff) ? Sat32Max : dq_d[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        if (den <= 34'sd0) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd48) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sgn_q     <= num[33] ^ neg_i;
      den_q     <= den[32:0];
      rem_q     <= '0;
      dq_q      <= {num_mag[32:0], 16'h0000};
      tan_q     <= neg_i ? Sat32Min : Sat32Max;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dq_q  <= dq_d;
      if (cnt_q == 6'd48) begin
        tan_q <= fin;
      end
    end
  end

  assign done_o = done_q;
  assign tan_o  = tan_q;

endmodule

### hdl/affine_transform_accumulator.sv
`timescale 1ns / 1ps
// Affine transform accumulator top level: sequencer, shared multiplier and matrix state.
// Depends on atacc_pkg, atacc_cordic and atacc_tan.
//
// Usage: one transform step is a transfer on the input channel (in_valid_i high, in_stall_o
// low). The step is right-multiplied into the 2x3 matrix and the matrix, a status bit and
// the step count come back as one transfer on the output channel.
// The block takes one step at a time and holds in_stall_o high while a step is at work.
// An ignored or refused step goes straight to the output; affine, translate and scale
// then run their multiply and add steps; rotate runs the CORDIC, then 16 multiply and add
// steps on the one shared 32x32 multiplier; skew does two CORDIC runs and two divisions
// before the 16 steps. The shared multiplier, the CORDIC loop and the divider set how
// long a step takes.
// Reset loads the identity matrix and a step count of zero; no clearing pass is needed.
// The result sits in an output register: a stalled receiver holds it there, and the next
// input step may already be accepted and worked on. A finished step waits only if the
// output register is still full.
module affine_transform_accumulator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         cmd_i,
  input  logic               start_req_i,
  input  logic signed [31:0] coef_xx_i,
  input  logic signed [31:0] coef_yx_i,
  input  logic signed [31:0] coef_xy_i,
  input  logic signed [31:0] coef_yy_i,
  input  logic signed [31:0] shift_x_i,
  input  logic signed [31:0] shift_y_i,
  input  logic signed [17:0] angle_a_i,
  input  logic signed [17:0] angle_b_i,
  input  logic signed [31:0] pivot_x_i,
  input  logic signed [31:0] pivot_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] out_xx_o,
  output logic signed [31:0] out_xy_o,
  output logic signed [31:0] out_tx_o,
  output logic signed [31:0] out_yx_o,
  output logic signed [31:0] out_yy_o,
  output logic signed [31:0] out_ty_o,
  output logic               status_o,
  output logic [5:0]         steps_done_o
);
  import atacc_pkg::*;

  state_e state_q, state_d;

  logic signed [31:0] acc_xx_q, acc_xy_q, acc_tx_q, acc_yx_q, acc_yy_q, acc_ty_q;
  logic [5:0]         steps_q, cnt_eff;
  logic signed [31:0] m_q [6];
  logic signed [31:0] res_q [5];
  logic signed [31:0] cx_q, cy_q;
  logic [2:0]         cmd_q;
  logic [16:0]        ang_a_q, ang_b_q;
  logic               skew_b_q, status_q;
  logic [3:0]         op_q;

  logic               accept, full, ignore, out_free;
  logic [3:0]         first_op;
  logic signed [31:0] op_a, op_b, base;
  logic               op_first, op_last, op_sub;
  logic signed [63:0] prod_q;
  logic signed [47:0] rnd;
  logic signed [50:0] sum_q, sum_d, prev;
  logic signed [31:0] sat_v;

  cordic_req_t        cor_req;
  cordic_rsp_t        cor_rsp;
  logic               tan_start, tan_done, tan_neg;
  logic signed [31:0] tan_v;
  logic signed [19:0] rc, rs;
  logic signed [31:0] rcx, rsx;

  logic signed [31:0] out_xx_q, out_xy_q, out_tx_q, out_yx_q, out_yy_q, out_ty_q;
  logic               out_valid_q, out_status_q;
  logic [5:0]         out_steps_q;

  assign accept   = (state_q == ST_IDLE) && in_valid_i;
  assign cnt_eff  = start_req_i ? 6'd0 : steps_q;
  assign ignore   = cmd_i > CMD_SKEW;
  assign full     = cnt_eff >= 6'(MaxSteps);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    unique case (cmd_i)
      CMD_SCALE, CMD_ROTATE, CMD_SKEW: first_op = 4'd0;
      default:                         first_op = 4'd4;
    endcase
  end

  atacc_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cor_req),
    .rsp_o  (cor_rsp)
  );

  atacc_tan u_tan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (tan_start),
    .neg_i   (tan_neg),
    .cos_i   (cor_rsp.cos_v),
    .sin_i   (cor_rsp.sin_v),
    .done_o  (tan_done),
    .tan_o   (tan_v)
  );

  assign tan_neg = skew_b_q ? ang_b_q[15] : ang_a_q[15];
  assign rc      = 20'((cor_rsp.cos_v + 34'sd8192) >>> 14);
  assign rs      = 20'((cor_rsp.sin_v + 34'sd8192) >>> 14);
  assign rcx     = 32'(rc);
  assign rsx     = 32'(rs);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (ignore || full) begin
            state_d = ST_DONE;
          end else if (cmd_i == CMD_ROTATE || cmd_i == CMD_SKEW) begin
            state_d = ST_COR;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_COR: begin
        if (cor_rsp.done) begin
          state_d = (cmd_q == CMD_SKEW) ? ST_TAN : ST_MUL;
        end
      end
      ST_TAN: begin
        if (tan_done) begin
          state_d = skew_b_q ? ST_MUL : ST_COR;
        end
      end
      ST_MUL: state_d = ST_ACC;
      ST_ACC: state_d = (op_q == 4'd15) ? ST_DONE : ST_MUL;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o      = state_q != ST_IDLE;
    cor_req.start   = 1'b0;
    cor_req.angle   = angle_a_i[14:0];
    tan_start       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cor_req.start = in_valid_i && !ignore && !full &&
                        (cmd_i == CMD_ROTATE || cmd_i == CMD_SKEW);
      end
      ST_COR: begin
        tan_start = cor_rsp.done && (cmd_q == CMD_SKEW);
      end
      ST_TAN: begin
        cor_req.start = tan_done && !skew_b_q;
        cor_req.angle = ang_b_q[14:0];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    op_a     = acc_xx_q;
    op_b     = m_q[0];
    base     = '0;
    op_first = 1'b0;
    op_last  = 1'b0;
    op_sub   = 1'b0;
    unique case (op_q)
      4'd0:  begin op_a = m_q[0];   op_b = cx_q;   base = cx_q; op_first = 1'b1; op_sub = 1'b1; end
      4'd1:  begin op_a = m_q[1];   op_b = cy_q;   op_last = 1'b1; op_sub = 1'b1; end
      4'd2:  begin op_a = m_q[3];   op_b = cx_q;   base = cy_q; op_first = 1'b1; op_sub = 1'b1; end
      4'd3:  begin op_a = m_q[4];   op_b = cy_q;   op_last = 1'b1; op_sub = 1'b1; end
      4'd4:  begin op_a = acc_xx_q; op_b = m_q[0]; op_first = 1'b1; end
      4'd5:  begin op_a = acc_xy_q; op_b = m_q[3]; op_last = 1'b1; end
      4'd6:  begin op_a = acc_xx_q; op_b = m_q[1]; op_first = 1'b1; end
      4'd7:  begin op_a = acc_xy_q; op_b = m_q[4]; op_last = 1'b1; end
      4'd8:  begin op_a = acc_xx_q; op_b = m_q[2]; base = acc_tx_q; op_first = 1'b1; end
      4'd9:  begin op_a = acc_xy_q; op_b = m_q[5]; op_last = 1'b1; end
      4'd10: begin op_a = acc_yx_q; op_b = m_q[0]; op_first = 1'b1; end
      4'd11: begin op_a = acc_yy_q; op_b = m_q[3]; op_last = 1'b1; end
      4'd12: begin op_a = acc_yx_q; op_b = m_q[1]; op_first = 1'b1; end
      4'd13: begin op_a = acc_yy_q; op_b = m_q[4]; op_last = 1'b1; end
      4'd14: begin op_a = acc_yx_q; op_b = m_q[2]; base = acc_ty_q; op_first = 1'b1; end
      4'd15: begin op_a = acc_yy_q; op_b = m_q[5]; op_last = 1'b1; end
      default: begin
      end
    endcase
  end

  always_comb begin
    rnd   = 48'((prod_q + 64'sd32768) >>> 16);
    prev  = op_first ? 51'(base) : sum_q;
    sum_d = op_sub ? (prev - 51'(rnd)) : (prev + 51'(rnd));
    sat_v = sat32_f(sum_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_xx_q    <= OneQ16;
      acc_xy_q    <= '0;
      acc_tx_q    <= '0;
      acc_yx_q    <= '0;
      acc_yy_q    <= OneQ16;
      acc_ty_q    <= '0;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
      skew_b_q    <= 1'b0;
      op_q        <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        skew_b_q <= 1'b0;
        op_q     <= first_op;
        if (start_req_i) begin
          acc_xx_q <= OneQ16;
          acc_xy_q <= '0;
          acc_tx_q <= '0;
          acc_yx_q <= '0;
          acc_yy_q <= OneQ16;
          acc_ty_q <= '0;
          steps_q  <= '0;
        end
      end
      if (state_q == ST_TAN && tan_done) begin
        skew_b_q <= 1'b1;
      end
      if (state_q == ST_ACC) begin
        op_q <= op_q + 4'd1;
        if (op_q == 4'd15) begin
          acc_xx_q <= res_q[0];
          acc_xy_q <= res_q[1];
          acc_tx_q <= res_q[2];
          acc_yx_q <= res_q[3];
          acc_yy_q <= res_q[4];
          acc_ty_q <= sat_v;
          steps_q  <= steps_q + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= cmd_i;
      ang_a_q  <= angle_a_i[16:0];
      ang_b_q  <= angle_b_i[16:0];
      cx_q     <= pivot_x_i;
      cy_q     <= pivot_y_i;
      status_q <= !ignore && full;
      m_q[0]   <= OneQ16;
      m_q[1]   <= '0;
      m_q[2]   <= '0;
      m_q[3]   <= '0;
      m_q[4]   <= OneQ16;
      m_q[5]   <= '0;
      priority case (cmd_i)
        CMD_AFFINE: begin
          m_q[0] <= coef_xx_i;
          m_q[3] <= coef_yx_i;
          m_q[1] <= coef_xy_i;
          m_q[4] <= coef_yy_i;
          m_q[2] <= shift_x_i;
          m_q[5] <= shift_y_i;
        end
        CMD_TRANSLATE: begin
          m_q[2] <= shift_x_i;
          m_q[5] <= shift_y_i;
        end
        CMD_SCALE: begin
          m_q[0] <= coef_xx_i;
          m_q[4] <= coef_yy_i;
        end
        default: begin
        end
      endcase
    end
    if (state_q == ST_COR && cor_rsp.done && cmd_q == CMD_ROTATE) begin
      unique case (ang_a_q[16:15])
        2'd0: begin
          m_q[0] <= rcx;  m_q[4] <= rcx;  m_q[3] <= rsx;  m_q[1] <= -rsx;
        end
        2'd1: begin
          m_q[0] <= -rsx; m_q[4] <= -rsx; m_q[3] <= rcx;  m_q[1] <= -rcx;
        end
        2'd2: begin
          m_q[0] <= -rcx; m_q[4] <= -rcx; m_q[3] <= -rsx; m_q[1] <= rsx;
        end
        default: begin
          m_q[0] <= rsx;  m_q[4] <= rsx;  m_q[3] <= -rcx; m_q[1] <= rcx;
        end
      endcase
    end
    if (state_q == ST_TAN && tan_done) begin
      if (skew_b_q) begin
        m_q[3] <= tan_v;
      end else begin
        m_q[1] <= (tan_v == Sat32Min) ? Sat32Max : -tan_v;
      end
    end
    if (state_q == ST_MUL) begin
      prod_q <= op_a * op_b;
    end
    if (state_q == ST_ACC) begin
      sum_q <= sum_d;
      if (op_last) begin
        unique case (op_q)
          4'd1:  m_q[2]   <= sat_v;
          4'd3:  m_q[5]   <= sat_v;
          4'd5:  res_q[0] <= sat_v;
          4'd7:  res_q[1] <= sat_v;
          4'd9:  res_q[2] <= sat_v;
          4'd11: res_q[3] <= sat_v;
          4'd13: res_q[4] <= sat_v;
          default: begin
          end
        endcase
      end
    end
    if (state_q == ST_DONE && out_free) begin
      out_xx_q     <= acc_xx_q;
      out_xy_q     <= acc_xy_q;
      out_tx_q     <= acc_tx_q;
      out_yx_q     <= acc_yx_q;
      out_yy_q     <= acc_yy_q;
      out_ty_q     <= acc_ty_q;
      out_status_q <= status_q;
      out_steps_q  <= steps_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_xx_o     = out_xx_q;
  assign out_xy_o     = out_xy_q;
  assign out_tx_o     = out_tx_q;
  assign out_yx_o     = out_yx_q;
  assign out_yy_o     = out_yy_q;
  assign out_ty_o     = out_ty_q;
  assign status_o     = out_status_q;
  assign steps_done_o = out_steps_q;

endmodule
